[rtl/magnetometer_smooth_calibrate_top_macros.svh]
// Assertion macros for the magnetometer smoothing and calibration block.
`ifndef MAGNETOMETER_SMOOTH_CALIBRATE_TOP_MACROS_SVH
`define MAGNETOMETER_SMOOTH_CALIBRATE_TOP_MACROS_SVH

// Same-edge implication, clocked on aclk, quiet during reset.
`define MAGSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, clocked on aclk, quiet during reset.
`define MAGSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/magsc_pkg.sv]
// Shared types and constants for the magnetometer smoothing and calibration block.
package magsc_pkg;

    localparam int RAW_W      = 16;
    localparam int SCALE_W    = 24;
    localparam int OFFS_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_XX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_XY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_XZ      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_YY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_YZ      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_ZZ      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_OFFSETS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE  = 3'd7;

    // reset values: matrix in Q2.14, gain 1.0 in Q8.16
    localparam logic [RAW_W-1:0]   SOFT_XX_RST      = 16'h3EBE;  // 16062
    localparam logic [RAW_W-1:0]   SOFT_XY_RST      = 16'hFF53;  // -173
    localparam logic [RAW_W-1:0]   SOFT_XZ_RST      = 16'h007C;  // 124
    localparam logic [RAW_W-1:0]   SOFT_YY_RST      = 16'h3CD7;  // 15575
    localparam logic [RAW_W-1:0]   SOFT_YZ_RST      = 16'hFDBA;  // -582
    localparam logic [RAW_W-1:0]   SOFT_ZZ_RST      = 16'h44C4;  // 17604
    localparam logic [OFFS_W-1:0]  HARD_OFFSETS_RST = 48'h0;
    localparam logic [SCALE_W-1:0] COUNT_SCALE_RST  = 24'h010000;

    typedef struct packed {
        logic [RAW_W-1:0]   soft_xx;
        logic [RAW_W-1:0]   soft_xy;
        logic [RAW_W-1:0]   soft_xz;
        logic [RAW_W-1:0]   soft_yy;
        logic [RAW_W-1:0]   soft_yz;
        logic [RAW_W-1:0]   soft_zz;
        logic [OFFS_W-1:0]  hard_offsets;
        logic [SCALE_W-1:0] count_scale;
    } cfg_t;

    typedef enum logic {
        OP_SCALE,
        OP_MATRIX
    } op_kind_t;

    // controller to datapath
    typedef struct packed {
        logic     load;      // take a good frame, update smoothed state
        logic     issue;     // drive the shared multiplier this cycle
        op_kind_t kind;
        logic     hi;        // upper slice of t in a matrix product
        logic [1:0] row;
        logic [1:0] col;
        logic     out_load;  // move finished item into output register
    } cmd_t;

endpackage

[rtl/magsc_cfg.sv]
// Configuration register bank for the magnetometer calibration block.
module magsc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [magsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [magsc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output magsc_pkg::cfg_t                     cfg
);

    magsc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soft_xx      <= magsc_pkg::SOFT_XX_RST;
            cfg_reg.soft_xy      <= magsc_pkg::SOFT_XY_RST;
            cfg_reg.soft_xz      <= magsc_pkg::SOFT_XZ_RST;
            cfg_reg.soft_yy      <= magsc_pkg::SOFT_YY_RST;
            cfg_reg.soft_yz      <= magsc_pkg::SOFT_YZ_RST;
            cfg_reg.soft_zz      <= magsc_pkg::SOFT_ZZ_RST;
            cfg_reg.hard_offsets <= magsc_pkg::HARD_OFFSETS_RST;
            cfg_reg.count_scale  <= magsc_pkg::COUNT_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                magsc_pkg::REG_SOFT_XX:      cfg_reg.soft_xx <= cfg_wr_data[15:0];
                magsc_pkg::REG_SOFT_XY:      cfg_reg.soft_xy <= cfg_wr_data[15:0];
                magsc_pkg::REG_SOFT_XZ:      cfg_reg.soft_xz <= cfg_wr_data[15:0];
                magsc_pkg::REG_SOFT_YY:      cfg_reg.soft_yy <= cfg_wr_data[15:0];
                magsc_pkg::REG_SOFT_YZ:      cfg_reg.soft_yz <= cfg_wr_data[15:0];
                magsc_pkg::REG_SOFT_ZZ:      cfg_reg.soft_zz <= cfg_wr_data[15:0];
                magsc_pkg::REG_HARD_OFFSETS: cfg_reg.hard_offsets <= cfg_wr_data[47:0];
                magsc_pkg::REG_COUNT_SCALE:  cfg_reg.count_scale <= cfg_wr_data[23:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/magsc_ctrl.sv]
// Sequencer for the magnetometer calibration block: handshakes and multiplier schedule.
module magsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_bus_error,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output magsc_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_MATRIX,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       half_reg, half_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd.load     = s_valid && (state_reg == S_IDLE) && !s_bus_error;
        cmd.issue    = (state_reg == S_SCALE) || (state_reg == S_MATRIX);
        cmd.kind     = (state_reg == S_MATRIX) ? magsc_pkg::OP_MATRIX : magsc_pkg::OP_SCALE;
        cmd.hi       = half_reg;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        half_next  = half_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_SCALE;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    half_next  = 1'b0;
                end
            end
            S_SCALE: begin
                if (col_reg == 2'd2) begin
                    state_next = S_MATRIX;
                    col_next   = 2'd0;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            S_MATRIX: begin
                half_next = !half_reg;
                if (half_reg) begin
                    if (col_reg == 2'd2) begin
                        col_next = 2'd0;
                        if (row_reg == 2'd2) begin
                            state_next = S_DRAIN;
                        end else begin
                            row_next = row_reg + 2'd1;
                        end
                    end else begin
                        col_next = col_reg + 2'd1;
                    end
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (cmd.out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            row_reg     <= 2'd0;
            col_reg     <= 2'd0;
            half_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            half_reg    <= half_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/magsc_dp.sv]
// Datapath: smoothing state, shared 17x25 multiplier, accumulators, output register.
module magsc_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  magsc_pkg::cmd_t         cmd,
    input  magsc_pkg::cfg_t         cfg,
    input  logic signed [15:0]      raw_x,
    input  logic signed [15:0]      raw_y,
    input  logic signed [15:0]      raw_z,
    output logic signed [15:0]      smooth_x,
    output logic signed [15:0]      smooth_y,
    output logic signed [15:0]      smooth_z,
    output logic signed [15:0]      field_x,
    output logic signed [15:0]      field_y,
    output logic signed [15:0]      field_z
);

    localparam logic [58:0] FIN_BIAS = 59'((64'd1 << 30) - 64'd1);

    // trunc((old + new) / 2)
    function automatic logic [15:0] avg16(input logic [15:0] old, input logic [15:0] nw);
        logic [16:0] sum;
        sum = {old[15], old} + {nw[15], nw};
        sum = sum + {16'b0, sum[16]};
        return sum[16:1];
    endfunction

    // Q.30 to integer, toward zero, saturated to int16
    function automatic logic [15:0] finish(input logic [58:0] acc);
        logic [58:0]        adj;
        logic signed [28:0] q;
        adj = acc + (acc[58] ? FIN_BIAS : 59'd0);
        q   = $signed(adj[58:30]);
        if (q > 29'sd32767) begin
            return 16'h7FFF;
        end else if (q < -29'sd32768) begin
            return 16'h8000;
        end else begin
            return q[15:0];
        end
    endfunction

    logic [15:0] smooth_reg [3];
    logic [40:0] t_reg      [3];
    logic [58:0] acc_reg    [3];

    logic signed [41:0] prod_reg;
    logic               prod_vld_reg;
    magsc_pkg::op_kind_t prod_kind_reg;
    logic               prod_hi_reg;
    logic [1:0]         prod_row_reg;
    logic [1:0]         prod_col_reg;

    logic [15:0] out_reg [6];

    logic [15:0]        neg_y, neg_z;
    logic [15:0]        m_sel;
    logic [40:0]        t_sel;
    logic [16:0]        mul_a;
    logic [24:0]        mul_b;
    logic signed [41:0] prod;
    logic [15:0]        off_sel;
    logic [40:0]        t_new;
    logic [58:0]        addend;

    // negation wraps at the most negative count
    assign neg_y = 16'(16'd0 - raw_y);
    assign neg_z = 16'(16'd0 - raw_z);

    // symmetric matrix element by row and column
    always_comb begin
        case ({cmd.row, cmd.col})
            4'b0000: m_sel = cfg.soft_xx;
            4'b0001: m_sel = cfg.soft_xy;
            4'b0010: m_sel = cfg.soft_xz;
            4'b0100: m_sel = cfg.soft_xy;
            4'b0101: m_sel = cfg.soft_yy;
            4'b0110: m_sel = cfg.soft_yz;
            4'b1000: m_sel = cfg.soft_xz;
            4'b1001: m_sel = cfg.soft_yz;
            4'b1010: m_sel = cfg.soft_zz;
            default: m_sel = 16'd0;
        endcase
    end

    // t is 41 bits: low 24 bits go in unsigned, high 17 bits signed
    always_comb begin
        t_sel = t_reg[cmd.col];
        if (cmd.kind == magsc_pkg::OP_SCALE) begin
            mul_a = {smooth_reg[cmd.col][15], smooth_reg[cmd.col]};
            mul_b = {1'b0, cfg.count_scale};
        end else begin
            mul_a = {m_sel[15], m_sel};
            mul_b = cmd.hi ? {{8{t_sel[40]}}, t_sel[40:24]} : {1'b0, t_sel[23:0]};
        end
        prod = $signed(mul_a) * $signed(mul_b);
    end

    always_comb begin
        case (prod_col_reg)
            2'd0:    off_sel = cfg.hard_offsets[15:0];
            2'd1:    off_sel = cfg.hard_offsets[31:16];
            2'd2:    off_sel = cfg.hard_offsets[47:32];
            default: off_sel = 16'd0;
        endcase
        t_new = prod_reg[40:0] - {{17{off_sel[15]}}, off_sel, 8'b0};
        // upper slice product fits 35 bits, weighted by 2^24
        addend = prod_hi_reg ? {prod_reg[34:0], 24'b0} : {{17{prod_reg[41]}}, prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg[0] <= 16'd0;
            smooth_reg[1] <= 16'd0;
            smooth_reg[2] <= 16'd0;
            prod_vld_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                smooth_reg[0] <= avg16(smooth_reg[0], raw_x);
                smooth_reg[1] <= avg16(smooth_reg[1], neg_y);
                smooth_reg[2] <= avg16(smooth_reg[2], neg_z);
            end
            prod_vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod;
        prod_kind_reg <= cmd.kind;
        prod_hi_reg   <= cmd.hi;
        prod_row_reg  <= cmd.row;
        prod_col_reg  <= cmd.col;
        if (cmd.load) begin
            acc_reg[0] <= 59'd0;
            acc_reg[1] <= 59'd0;
            acc_reg[2] <= 59'd0;
        end else if (prod_vld_reg) begin
            if (prod_kind_reg == magsc_pkg::OP_SCALE) begin
                t_reg[prod_col_reg] <= t_new;
            end else begin
                acc_reg[prod_row_reg] <= acc_reg[prod_row_reg] + addend;
            end
        end
        if (cmd.out_load) begin
            out_reg[0] <= smooth_reg[0];
            out_reg[1] <= smooth_reg[1];
            out_reg[2] <= smooth_reg[2];
            out_reg[3] <= finish(acc_reg[0]);
            out_reg[4] <= finish(acc_reg[1]);
            out_reg[5] <= finish(acc_reg[2]);
        end
    end

    assign smooth_x = out_reg[0];
    assign smooth_y = out_reg[1];
    assign smooth_z = out_reg[2];
    assign field_x  = out_reg[3];
    assign field_y  = out_reg[4];
    assign field_z  = out_reg[5];

endmodule

[rtl/magnetometer_smooth_calibrate_top.sv]
// Top level of the magnetometer smoothing and hard/soft-iron calibration block.
//
// Input channel s_*: one three-axis frame of raw counts per item, plus a bus
// error flag. A flagged item is taken and dropped: no result, no
// change to the smoothed state. Output channel m_*: smoothed counts (y and z
// negated) and the calibrated field, one item per good frame, in order.
// Configuration: cfg_wr_en / cfg_index / cfg_wr_data write one register per
// cycle; write only while no item is in flight.
// A good item accepted while idle passes through the scale, matrix, drain and
// done states, and m_valid rises once the output register is free.
// The schedule is set by the single shared 17x25 multiplier: three scale
// products then nine matrix products, each split into two slices of t, with
// a product register, then a drain state and a finishing state.
// s_ready is high only while the sequencer is idle; a finished item waits in
// the output register while the next item is accepted and worked on. If the
// receiver stalls, the next result is held back and s_ready stays low.
// Reset (aresetn, synchronous, active low) restores the default matrix, zero
// offsets, unit gain, clears the smoothed state and empties the output.
`include "magnetometer_smooth_calibrate_top_macros.svh"

module magnetometer_smooth_calibrate_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [magsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [magsc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_raw_x,
    input  logic signed [15:0]                  s_raw_y,
    input  logic signed [15:0]                  s_raw_z,
    input  logic                                s_bus_error,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_smooth_x,
    output logic signed [15:0]                  m_smooth_y,
    output logic signed [15:0]                  m_smooth_z,
    output logic signed [15:0]                  m_field_x,
    output logic signed [15:0]                  m_field_y,
    output logic signed [15:0]                  m_field_z
);

    magsc_pkg::cfg_t cfg;
    magsc_pkg::cmd_t cmd;

    // register bank
    magsc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // sequencer: handshakes and multiplier schedule
    magsc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_bus_error (s_bus_error),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    // arithmetic and output register
    magsc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .raw_x    (s_raw_x),
        .raw_y    (s_raw_y),
        .raw_z    (s_raw_z),
        .smooth_x (m_smooth_x),
        .smooth_y (m_smooth_y),
        .smooth_z (m_smooth_z),
        .field_x  (m_field_x),
        .field_y  (m_field_y),
        .field_z  (m_field_z)
    );

    // a dropped frame must not start the sequencer
    `MAGSC_ASSERT_NEXT(a_err_frame_idle, s_valid && s_ready && s_bus_error, s_ready, "bus error item started work")
    // a good frame must occupy the sequencer
    `MAGSC_ASSERT_NEXT(a_good_frame_busy, s_valid && s_ready && !s_bus_error, !s_ready, "good item not processed")
    // results appear only from the finishing state, never while idle
    `MAGSC_ASSERT_NOW(a_result_from_done, $rose(m_valid), $past(!s_ready), "result without work")

endmodule

[dv/magsc_checker.sv]
// Result checker for the magnetometer smoothing and calibration block.
`timescale 1ns / 1ps

module magsc_checker
    import magsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic signed [15:0]     s_raw_x,
    input  logic signed [15:0]     s_raw_y,
    input  logic signed [15:0]     s_raw_z,
    input  logic                   s_bus_error,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic signed [15:0]     m_smooth_x,
    input  logic signed [15:0]     m_smooth_y,
    input  logic signed [15:0]     m_smooth_z,
    input  logic signed [15:0]     m_field_x,
    input  logic signed [15:0]     m_field_y,
    input  logic signed [15:0]     m_field_z,
    output int                     fail_count,
    output int                     results_pending
);

    localparam longint Q30_ONE = 64'sd1 <<< 30;

    typedef struct {
        logic signed [15:0] smooth_x;
        logic signed [15:0] smooth_y;
        logic signed [15:0] smooth_z;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
    } calib_result_t;

    cfg_t               cfg_q;
    logic signed [15:0] smooth_x_q, smooth_y_q, smooth_z_q;
    calib_result_t      expected_fields[$];
    calib_result_t      want;

    initial begin
        fail_count      = 0;
        results_pending = 0;
    end

    function automatic logic signed [15:0] negate_wrap(input logic signed [15:0] v);
        int n;
        n = -int'(v);
        if (n > 32767) n = -32768;
        return 16'(n);
    endfunction

    function automatic logic signed [15:0] half_sum(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
        int s;
        s = int'(a) + int'(b);
        return 16'(s / 2);
    endfunction

    function automatic logic signed [15:0] field_clamp(input longint acc);
        longint q;
        q = acc / Q30_ONE;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    // smooths the frame into the held state, then applies gain, offset and matrix
    function automatic calib_result_t calibrate_frame(input logic signed [15:0] rx,
                                                      input logic signed [15:0] ry,
                                                      input logic signed [15:0] rz);
        calib_result_t r;
        longint gain, tx, ty, tz;
        longint mxx, mxy, mxz, myy, myz, mzz;
        smooth_x_q = half_sum(smooth_x_q, rx);
        smooth_y_q = half_sum(smooth_y_q, negate_wrap(ry));
        smooth_z_q = half_sum(smooth_z_q, negate_wrap(rz));
        gain = longint'(cfg_q.count_scale);
        tx = longint'(smooth_x_q) * gain
             - longint'($signed(cfg_q.hard_offsets[15:0])) * 256;
        ty = longint'(smooth_y_q) * gain
             - longint'($signed(cfg_q.hard_offsets[31:16])) * 256;
        tz = longint'(smooth_z_q) * gain
             - longint'($signed(cfg_q.hard_offsets[47:32])) * 256;
        mxx = longint'($signed(cfg_q.soft_xx));
        mxy = longint'($signed(cfg_q.soft_xy));
        mxz = longint'($signed(cfg_q.soft_xz));
        myy = longint'($signed(cfg_q.soft_yy));
        myz = longint'($signed(cfg_q.soft_yz));
        mzz = longint'($signed(cfg_q.soft_zz));
        r.smooth_x = smooth_x_q;
        r.smooth_y = smooth_y_q;
        r.smooth_z = smooth_z_q;
        r.field_x  = field_clamp(mxx * tx + mxy * ty + mxz * tz);
        r.field_y  = field_clamp(mxy * tx + myy * ty + myz * tz);
        r.field_z  = field_clamp(mxz * tx + myz * ty + mzz * tz);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [15:0] exp_v,
                                 input logic signed [15:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_q.soft_xx      = SOFT_XX_RST;
            cfg_q.soft_xy      = SOFT_XY_RST;
            cfg_q.soft_xz      = SOFT_XZ_RST;
            cfg_q.soft_yy      = SOFT_YY_RST;
            cfg_q.soft_yz      = SOFT_YZ_RST;
            cfg_q.soft_zz      = SOFT_ZZ_RST;
            cfg_q.hard_offsets = HARD_OFFSETS_RST;
            cfg_q.count_scale  = COUNT_SCALE_RST;
            smooth_x_q = '0;
            smooth_y_q = '0;
            smooth_z_q = '0;
            expected_fields.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SOFT_XX:      cfg_q.soft_xx      = cfg_wr_data[15:0];
                    REG_SOFT_XY:      cfg_q.soft_xy      = cfg_wr_data[15:0];
                    REG_SOFT_XZ:      cfg_q.soft_xz      = cfg_wr_data[15:0];
                    REG_SOFT_YY:      cfg_q.soft_yy      = cfg_wr_data[15:0];
                    REG_SOFT_YZ:      cfg_q.soft_yz      = cfg_wr_data[15:0];
                    REG_SOFT_ZZ:      cfg_q.soft_zz      = cfg_wr_data[15:0];
                    REG_HARD_OFFSETS: cfg_q.hard_offsets = cfg_wr_data[47:0];
                    REG_COUNT_SCALE:  cfg_q.count_scale  = cfg_wr_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready && !s_bus_error)
                expected_fields.push_back(calibrate_frame(s_raw_x, s_raw_y, s_raw_z));
            if (m_valid && m_ready) begin
                if (expected_fields.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d / %0d %0d %0d",
                             $time, m_smooth_x, m_smooth_y, m_smooth_z,
                             m_field_x, m_field_y, m_field_z);
                    fail_count++;
                end else begin
                    want = expected_fields.pop_front();
                    compare_field("smooth_x", want.smooth_x, m_smooth_x);
                    compare_field("smooth_y", want.smooth_y, m_smooth_y);
                    compare_field("smooth_z", want.smooth_z, m_smooth_z);
                    compare_field("field_x", want.field_x, m_field_x);
                    compare_field("field_y", want.field_y, m_field_y);
                    compare_field("field_z", want.field_z, m_field_z);
                end
            end
        end
        results_pending <= expected_fields.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, stimulus, configuration and verdict for the calibration block.
`timescale 1ns / 1ps

module tb_top;
    import magsc_pkg::*;

    localparam int BUSY_PCT        = 79;   // heavy idling / stalling
    localparam int LIGHT_PCT       = 8;    // light idling on both sides
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 190;  // good frames per phase
    localparam int SETTLE_CYCLES   = 40;   // comfortably above the time one item takes in the sequencer
    localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 4000; // quiet cycles before giving up

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic signed [15:0]    s_raw_x     = '0;
    logic signed [15:0]    s_raw_y     = '0;
    logic signed [15:0]    s_raw_z     = '0;
    logic                  s_bus_error = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic signed [15:0]    m_smooth_x, m_smooth_y, m_smooth_z;
    logic signed [15:0]    m_field_x, m_field_y, m_field_z;

    int fail_count;
    int results_pending;

    // idling knobs, changed per phase by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;

    // last frame sent, reused now and then so the smoothing settles
    logic [15:0] last_x = '0, last_y = '0, last_z = '0;

    always #4 aclk = ~aclk;

    magnetometer_smooth_calibrate_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_raw_x     (s_raw_x),
        .s_raw_y     (s_raw_y),
        .s_raw_z     (s_raw_z),
        .s_bus_error (s_bus_error),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_smooth_x  (m_smooth_x),
        .m_smooth_y  (m_smooth_y),
        .m_smooth_z  (m_smooth_z),
        .m_field_x   (m_field_x),
        .m_field_y   (m_field_y),
        .m_field_z   (m_field_z)
    );

    magsc_checker result_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_x         (s_raw_x),
        .s_raw_y         (s_raw_y),
        .s_raw_z         (s_raw_z),
        .s_bus_error     (s_bus_error),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smooth_x      (m_smooth_x),
        .m_smooth_y      (m_smooth_y),
        .m_smooth_z      (m_smooth_z),
        .m_field_x       (m_field_x),
        .m_field_y       (m_field_y),
        .m_field_z       (m_field_z),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    // At most one assignment to m_ready per edge.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [47:0] random_word48();
        return 48'({$urandom, $urandom});
    endfunction

    // mostly full-range counts, some near zero, some at the rails
    function automatic logic [15:0] random_count();
        case ($urandom_range(7))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6:          return 16'(int'($urandom_range(128)) - 64);
            default: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    // One register write; the enable drops on the following edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic program_all(input logic [47:0] xx, input logic [47:0] xy,
                               input logic [47:0] xz, input logic [47:0] yy,
                               input logic [47:0] yz, input logic [47:0] zz,
                               input logic [47:0] offs, input logic [47:0] gain);
        write_reg(REG_SOFT_XX, xx);
        write_reg(REG_SOFT_XY, xy);
        write_reg(REG_SOFT_XZ, xz);
        write_reg(REG_SOFT_YY, yy);
        write_reg(REG_SOFT_YZ, yz);
        write_reg(REG_SOFT_ZZ, zz);
        write_reg(REG_HARD_OFFSETS, offs);
        write_reg(REG_COUNT_SCALE, gain);
    endtask

    // Offer one item and return at the edge where it is taken.
    // Valid only drops on an idle gap, never between back-to-back items.
    task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic err);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_raw_x     <= x;
        s_raw_y     <= y;
        s_raw_z     <= z;
        s_bus_error <= err;
        do @(posedge aclk); while (!s_ready);
        last_x = x;
        last_y = y;
        last_z = z;
    endtask

    // Sender goes quiet until every expected result is back, then lets the
    // block finish any dropped item before anything else happens.
    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Rails, negation wrap on y and z, odd sums that truncate toward zero,
    // and bus-error items carrying values that would otherwise upset the state.
    task automatic run_directed();
        send_frame(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_frame(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
        send_frame(16'h0001, 16'hFFFF, 16'h0001, 1'b0);
        send_frame(16'h8000, 16'h0000, 16'h0000, 1'b1);
        send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_frame(16'h0000, 16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'sd12345, -16'sd23456, 16'sd3210, 1'b0);
        send_frame(-16'sd3, -16'sd5, 16'sd7, 1'b0);
    endtask

    // Main stimulus
    initial begin
        int          good;
        int          send_pcts[4];
        int          recv_pcts[4];
        logic [15:0] x, y, z;
        logic        err;

        // idling pattern cycles through: none, sender busy, receiver busy, both light
        send_pcts = '{0, BUSY_PCT, 0, LIGHT_PCT};
        recv_pcts = '{0, 0, BUSY_PCT, LIGHT_PCT};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset matrix and gain first
        run_directed();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle_idle();
            case (phase)
                1: program_all(48'd16384, 48'd0, 48'd0, 48'd16384, 48'd0, 48'd16384,
                               48'd0, 48'h010000);
                2: program_all(48'h8000, 48'h8000, 48'h8000, 48'h8000, 48'h8000, 48'h8000,
                               48'h8000_8000_8000, 48'hFF_FFFF);
                3: program_all(48'h7FFF, 48'h7FFF, 48'h7FFF, 48'h7FFF, 48'h7FFF, 48'h7FFF,
                               48'h7FFF_7FFF_7FFF, 48'hFF_FFFF);
                4: program_all(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0,
                               random_word48(), 48'd0);
                5, 6, 7: program_all(random_word48(), random_word48(), random_word48(),
                                     random_word48(), random_word48(), random_word48(),
                                     random_word48(), random_word48());
                default: ;
            endcase
            send_idle_pct  = send_pcts[phase % 4];
            recv_stall_pct = recv_pcts[phase % 4];

            // saturating settings see the rail cases too
            if (phase == 2) run_directed();

            good = 0;
            while (good < ITEMS_PER_PHASE) begin
                // long hold-off while the sender keeps pushing: the block backs up
                if (phase == 4 && good == 40) hold_len = HOLD_CYCLES;
                // sender pauses mid-phase until every result is back
                if (phase == 5 && good == ITEMS_PER_PHASE / 2) settle_idle();
                if ($urandom_range(3) == 0) begin
                    x = last_x;
                    y = last_y;
                    z = last_z;
                end else begin
                    x = random_count();
                    y = random_count();
                    z = random_count();
                end
                err = ($urandom_range(9) == 0);
                send_frame(x, y, z, err);
                if (!err) good++;
            end
        end

        settle_idle();

        if (fail_count == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/magsc_pkg.sv
rtl/magsc_cfg.sv
rtl/magsc_ctrl.sv
rtl/magsc_dp.sv
rtl/magnetometer_smooth_calibrate_top.sv
dv/magsc_checker.sv
dv/tb_top.sv
